// ===== hdl/slot_and_first_fit_block_allocator_core_assert.svh =====
// assertion macros for the allocator checker
`ifndef SLOT_AND_FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define SLOT_AND_FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define SAFFBA_ASSERT_NOW(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("allocator check failed");

// next-cycle implication
`define SAFFBA_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("allocator check failed");

`endif

// ===== hdl/saffba_pkg.sv =====
package saffba_pkg;

  localparam int SLOT_COUNT_DEF      = 1024;
  localparam int POOL_WORDS_DEF      = 67108864;
  localparam int FREE_LIST_DEPTH_DEF = 1025;

  localparam int CNT_W  = 27;
  localparam int SID_W  = 11;
  localparam int OFS_W  = 26;
  localparam int STAT_W = 3;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_SLOT   = 3'd1,
    STAT_POOL_FULL = 3'd2,
    STAT_INVALID   = 3'd3,
    STAT_LIST_FULL = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_A_SLOT,
    S_A_RD,
    S_A_CHK,
    S_RM_RD,
    S_RM_WR,
    S_R_RD,
    S_R_CHK,
    S_R_DEC,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

endpackage

// ===== hdl/slot_and_first_fit_block_allocator_core.sv =====
// an allocation with no slot left, an invalid slot or a release that returns no block goes
// from decode straight to done, a zero-count allocation takes a slot and is then done, else the
// free list is walked entry by entry, with entries shifted on delete or insert
// a new request is taken only once the result is out and the block is back in idle
// result strobe out_valid lasts one cycle and cannot be stalled
// after reset the slot stack is refilled with busy high
module slot_and_first_fit_block_allocator_core #(
  parameter int SLOT_COUNT      = saffba_pkg::SLOT_COUNT_DEF,
  parameter int POOL_WORDS      = saffba_pkg::POOL_WORDS_DEF,
  parameter int FREE_LIST_DEPTH = saffba_pkg::FREE_LIST_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [saffba_pkg::CNT_W-1:0]  in_item_count,
  input  logic [saffba_pkg::SID_W-1:0]  in_slot_id,
  input  logic [saffba_pkg::OFS_W-1:0]  in_release_offset,
  output logic                          out_valid,
  output logic [saffba_pkg::STAT_W-1:0] out_status,
  output logic [saffba_pkg::SID_W-1:0]  out_granted_slot,
  output logic [saffba_pkg::OFS_W-1:0]  out_granted_offset
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int DW = $clog2(SLOT_COUNT + 1);
  localparam int FW = $clog2(FREE_LIST_DEPTH);
  localparam int TW = $clog2(FREE_LIST_DEPTH + 1);
  localparam int LW = $clog2(POOL_WORDS + 1);
  localparam int OW = $clog2(POOL_WORDS);
  localparam int AW = (LW > saffba_pkg::CNT_W) ? LW : saffba_pkg::CNT_W;

  saffba_pkg::state_t  state_r, state_nxt;
  saffba_pkg::status_t stat_r, stat_nxt;

  logic [SW-1:0] init_r, init_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [TW-1:0] pos_r, pos_nxt;
  logic [TW-1:0] idx_r, idx_nxt;
  logic          req_r, req_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [saffba_pkg::SID_W-1:0] sid_r, sid_nxt;
  logic [saffba_pkg::OFS_W-1:0] off_r, off_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [AW-1:0] prev_end_r, prev_end_nxt;
  logic [AW-1:0] prev_len_r, prev_len_nxt;
  logic [AW-1:0] next_start_r, next_start_nxt;
  logic [AW-1:0] next_len_r, next_len_nxt;
  logic          next_vld_r, next_vld_nxt;
  logic [saffba_pkg::SID_W-1:0] gslot_r, gslot_nxt;
  logic [saffba_pkg::OFS_W-1:0] gofs_r, gofs_nxt;

  logic [SW-1:0] stk_mem [SLOT_COUNT];
  logic          stk_re, stk_we;
  logic [SW-1:0] stk_raddr, stk_waddr, stk_wdata, stk_q;

  logic [OW-1:0] fls_mem [FREE_LIST_DEPTH];
  logic [LW-1:0] fll_mem [FREE_LIST_DEPTH];
  logic          fl_re, fls_we, fll_we;
  logic [FW-1:0] fl_raddr, fl_waddr;
  logic [OW-1:0] fls_wdata, start_q;
  logic [LW-1:0] fll_wdata, len_q;

  logic [AW-1:0] off_ext, room, clip_cnt, end_cur;
  logic          mprev, mnext;

  assign off_ext  = AW'(off_r);
  assign room     = AW'(POOL_WORDS) - off_ext;
  assign clip_cnt = (cnt_r > room) ? room : cnt_r;
  assign end_cur  = off_ext + cnt_r;
  assign mprev    = (pos_r != '0) && (prev_end_r == off_ext);
  assign mnext    = next_vld_r && (end_cur == next_start_r);

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_raddr];
    end
    if (fls_we) begin
      fls_mem[fl_waddr] <= fls_wdata;
    end
    if (fll_we) begin
      fll_mem[fl_waddr] <= fll_wdata;
    end
    if (fl_re) begin
      start_q <= fls_mem[fl_raddr];
      len_q   <= fll_mem[fl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= saffba_pkg::S_INIT;
      init_r  <= '0;
      depth_r <= DW'(SLOT_COUNT);
      total_r <= TW'(1);
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      depth_r <= depth_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r       <= stat_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    req_r        <= req_nxt;
    cnt_r        <= cnt_nxt;
    sid_r        <= sid_nxt;
    off_r        <= off_nxt;
    slot_r       <= slot_nxt;
    prev_end_r   <= prev_end_nxt;
    prev_len_r   <= prev_len_nxt;
    next_start_r <= next_start_nxt;
    next_len_r   <= next_len_nxt;
    next_vld_r   <= next_vld_nxt;
    gslot_r      <= gslot_nxt;
    gofs_r       <= gofs_nxt;
  end

  // next state and datapath registers
  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    depth_nxt      = depth_r;
    total_nxt      = total_r;
    stat_nxt       = stat_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    req_nxt        = req_r;
    cnt_nxt        = cnt_r;
    sid_nxt        = sid_r;
    off_nxt        = off_r;
    slot_nxt       = slot_r;
    prev_end_nxt   = prev_end_r;
    prev_len_nxt   = prev_len_r;
    next_start_nxt = next_start_r;
    next_len_nxt   = next_len_r;
    next_vld_nxt   = next_vld_r;
    gslot_nxt      = gslot_r;
    gofs_nxt       = gofs_r;
    case (state_r)
      saffba_pkg::S_INIT: begin
        init_nxt = init_r + SW'(1);
        if (init_r == SW'(SLOT_COUNT - 1)) begin
          state_nxt = saffba_pkg::S_IDLE;
        end
      end
      saffba_pkg::S_IDLE: begin
        if (start) begin
          req_nxt   = in_req_type;
          cnt_nxt   = AW'(in_item_count);
          sid_nxt   = in_slot_id;
          off_nxt   = in_release_offset;
          state_nxt = saffba_pkg::S_DECODE;
        end
      end
      saffba_pkg::S_DECODE: begin
        stat_nxt  = saffba_pkg::STAT_OK;
        gslot_nxt = saffba_pkg::SID_W'(SLOT_COUNT);
        gofs_nxt  = '0;
        pos_nxt   = '0;
        if (!req_r) begin
          if (depth_r == '0) begin
            stat_nxt  = saffba_pkg::STAT_NO_SLOT;
            state_nxt = saffba_pkg::S_DONE;
          end else begin
            state_nxt = saffba_pkg::S_A_SLOT;
          end
        end else if (32'(sid_r) >= SLOT_COUNT) begin
          stat_nxt  = saffba_pkg::STAT_INVALID;
          state_nxt = saffba_pkg::S_DONE;
        end else begin
          if (depth_r < DW'(SLOT_COUNT)) begin
            depth_nxt = depth_r + DW'(1);
          end
          cnt_nxt = clip_cnt;
          if (off_ext >= AW'(POOL_WORDS) || clip_cnt == '0) begin
            state_nxt = saffba_pkg::S_DONE;
          end else begin
            state_nxt = saffba_pkg::S_R_RD;
          end
        end
      end
      saffba_pkg::S_A_SLOT: begin
        slot_nxt = stk_q;
        if (cnt_r == '0) begin
          depth_nxt = depth_r - DW'(1);
          gslot_nxt = saffba_pkg::SID_W'(stk_q);
          state_nxt = saffba_pkg::S_DONE;
        end else begin
          state_nxt = saffba_pkg::S_A_RD;
        end
      end
      saffba_pkg::S_A_RD: begin
        if (pos_r >= total_r) begin
          stat_nxt  = saffba_pkg::STAT_POOL_FULL;
          state_nxt = saffba_pkg::S_DONE;
        end else begin
          state_nxt = saffba_pkg::S_A_CHK;
        end
      end
      saffba_pkg::S_A_CHK: begin
        if (AW'(len_q) >= cnt_r) begin
          depth_nxt = depth_r - DW'(1);
          gslot_nxt = saffba_pkg::SID_W'(slot_r);
          gofs_nxt  = saffba_pkg::OFS_W'(start_q);
          if (AW'(len_q) == cnt_r) begin
            state_nxt = saffba_pkg::S_RM_RD;
          end else begin
            state_nxt = saffba_pkg::S_DONE;
          end
        end else begin
          pos_nxt   = pos_r + TW'(1);
          state_nxt = saffba_pkg::S_A_RD;
        end
      end
      saffba_pkg::S_RM_RD: begin
        if ((TW + 1)'(pos_r) + (TW + 1)'(1) >= (TW + 1)'(total_r)) begin
          total_nxt = total_r - TW'(1);
          state_nxt = saffba_pkg::S_DONE;
        end else begin
          state_nxt = saffba_pkg::S_RM_WR;
        end
      end
      saffba_pkg::S_RM_WR: begin
        pos_nxt   = pos_r + TW'(1);
        state_nxt = saffba_pkg::S_RM_RD;
      end
      saffba_pkg::S_R_RD: begin
        if (pos_r >= total_r) begin
          next_vld_nxt = 1'b0;
          state_nxt    = saffba_pkg::S_R_DEC;
        end else begin
          state_nxt = saffba_pkg::S_R_CHK;
        end
      end
      saffba_pkg::S_R_CHK: begin
        if (AW'(start_q) < off_ext) begin
          prev_end_nxt = AW'(start_q) + AW'(len_q);
          prev_len_nxt = AW'(len_q);
          pos_nxt      = pos_r + TW'(1);
          state_nxt    = saffba_pkg::S_R_RD;
        end else begin
          next_start_nxt = AW'(start_q);
          next_len_nxt   = AW'(len_q);
          next_vld_nxt   = 1'b1;
          state_nxt      = saffba_pkg::S_R_DEC;
        end
      end
      saffba_pkg::S_R_DEC: begin
        if (mprev && mnext) begin
          state_nxt = saffba_pkg::S_RM_RD;
        end else if (mprev || mnext) begin
          state_nxt = saffba_pkg::S_DONE;
        end else if (32'(total_r) >= FREE_LIST_DEPTH) begin
          stat_nxt  = saffba_pkg::STAT_LIST_FULL;
          state_nxt = saffba_pkg::S_DONE;
        end else begin
          idx_nxt   = total_r;
          state_nxt = saffba_pkg::S_SH_RD;
        end
      end
      saffba_pkg::S_SH_RD: begin
        if (idx_r == pos_r) begin
          total_nxt = total_r + TW'(1);
          state_nxt = saffba_pkg::S_DONE;
        end else begin
          state_nxt = saffba_pkg::S_SH_WR;
        end
      end
      saffba_pkg::S_SH_WR: begin
        idx_nxt   = idx_r - TW'(1);
        state_nxt = saffba_pkg::S_SH_RD;
      end
      saffba_pkg::S_DONE: begin
        state_nxt = saffba_pkg::S_IDLE;
      end
      default: begin
        state_nxt = saffba_pkg::S_IDLE;
      end
    endcase
  end

  // memory strobes and ports
  always_comb begin
    stk_re    = 1'b0;
    stk_we    = 1'b0;
    stk_raddr = depth_r[SW-1:0] - SW'(1);
    stk_waddr = depth_r[SW-1:0];
    stk_wdata = SW'(sid_r);
    fl_re     = 1'b0;
    fls_we    = 1'b0;
    fll_we    = 1'b0;
    fl_raddr  = pos_r[FW-1:0];
    fl_waddr  = pos_r[FW-1:0];
    fls_wdata = start_q;
    fll_wdata = len_q;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      saffba_pkg::S_INIT: begin
        stk_we    = 1'b1;
        stk_waddr = init_r;
        stk_wdata = SW'(SLOT_COUNT - 1) - init_r;
        if (init_r == '0) begin
          fls_we    = 1'b1;
          fll_we    = 1'b1;
          fl_waddr  = '0;
          fls_wdata = '0;
          fll_wdata = LW'(POOL_WORDS);
        end
      end
      saffba_pkg::S_IDLE: begin
        busy = 1'b0;
      end
      saffba_pkg::S_DECODE: begin
        if (!req_r) begin
          stk_re = 1'b1;
        end else if (32'(sid_r) < SLOT_COUNT && depth_r < DW'(SLOT_COUNT)) begin
          stk_we = 1'b1;
        end
      end
      saffba_pkg::S_A_RD, saffba_pkg::S_R_RD: begin
        fl_re = (pos_r < total_r);
      end
      saffba_pkg::S_A_CHK: begin
        if (AW'(len_q) > cnt_r) begin
          fls_we    = 1'b1;
          fll_we    = 1'b1;
          fls_wdata = OW'(AW'(start_q) + cnt_r);
          fll_wdata = LW'(AW'(len_q) - cnt_r);
        end
      end
      saffba_pkg::S_RM_RD: begin
        fl_re    = 1'b1;
        fl_raddr = pos_r[FW-1:0] + FW'(1);
      end
      saffba_pkg::S_RM_WR: begin
        fls_we = 1'b1;
        fll_we = 1'b1;
      end
      saffba_pkg::S_R_DEC: begin
        if (mprev) begin
          fll_we   = 1'b1;
          fl_waddr = pos_r[FW-1:0] - FW'(1);
          if (mnext) begin
            fll_wdata = LW'(prev_len_r + cnt_r + next_len_r);
          end else begin
            fll_wdata = LW'(prev_len_r + cnt_r);
          end
        end else if (mnext) begin
          fls_we    = 1'b1;
          fll_we    = 1'b1;
          fls_wdata = OW'(off_r);
          fll_wdata = LW'(next_len_r + cnt_r);
        end
      end
      saffba_pkg::S_SH_RD: begin
        if (idx_r == pos_r) begin
          fls_we    = 1'b1;
          fll_we    = 1'b1;
          fls_wdata = OW'(off_r);
          fll_wdata = LW'(cnt_r);
        end else begin
          fl_re    = 1'b1;
          fl_raddr = idx_r[FW-1:0] - FW'(1);
        end
      end
      saffba_pkg::S_SH_WR: begin
        fls_we   = 1'b1;
        fll_we   = 1'b1;
        fl_waddr = idx_r[FW-1:0];
      end
      saffba_pkg::S_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign out_status         = stat_r;
  assign out_granted_slot   = gslot_r;
  assign out_granted_offset = gofs_r;

endmodule

// ===== hdl/saffba_chk.sv =====
`include "slot_and_first_fit_block_allocator_core_assert.svh"

module saffba_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [saffba_pkg::STAT_W-1:0] out_status,
  input logic [saffba_pkg::OFS_W-1:0]  out_granted_offset
);

  `SAFFBA_ASSERT_NOW(a_strobe_busy, clk, rst_n, out_valid, busy)
  `SAFFBA_ASSERT_NEXT(a_strobe_pulse, clk, rst_n, out_valid, !out_valid)
  `SAFFBA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `SAFFBA_ASSERT_NOW(a_fail_ofs, clk, rst_n,
    out_valid && out_status != saffba_pkg::STAT_OK, out_granted_offset == '0)

endmodule

bind slot_and_first_fit_block_allocator_core saffba_chk u_saffba_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_status         (out_status),
  .out_granted_offset (out_granted_offset)
);

// ===== tb/slot_and_first_fit_block_allocator_core_tb.sv =====
`timescale 1ns / 1ps

module slot_and_first_fit_block_allocator_core_tb;

  localparam int NSLOT = saffba_pkg::SLOT_COUNT_DEF;
  localparam int NPOOL = saffba_pkg::POOL_WORDS_DEF;
  localparam int NFREE = saffba_pkg::FREE_LIST_DEPTH_DEF;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;
  localparam logic [saffba_pkg::SID_W-1:0] NO_GRANT = saffba_pkg::SID_W'(NSLOT);
  localparam int RANDOM_ITEMS = 820;
  localparam longint CYCLE_LIMIT = 100000000;

  typedef struct packed {
    logic [saffba_pkg::STAT_W-1:0] status;
    logic [saffba_pkg::SID_W-1:0] slot;
    logic [saffba_pkg::OFS_W-1:0] offset;
  } grant_t;

  typedef struct {
    logic [saffba_pkg::SID_W-1:0] slot;
    logic [saffba_pkg::OFS_W-1:0] offset;
    logic [saffba_pkg::CNT_W-1:0] count;
  } lease_t;

  class alloc_scoreboard;
    int unsigned slot_stack[NSLOT];
    int unsigned slot_depth;
    int unsigned blk_start[NFREE];
    int unsigned blk_len[NFREE];
    int unsigned blk_total;
    grant_t pending[$];
    int mismatches;

    function new();
      for (int i = 0; i < NSLOT; i++) slot_stack[i] = NSLOT - 1 - i;
      slot_depth = NSLOT;
      for (int i = 0; i < NFREE; i++) begin
        blk_start[i] = 0;
        blk_len[i] = 0;
      end
      blk_len[0] = NPOOL;
      blk_total = 1;
      mismatches = 0;
    endfunction

    function void drop_block(int unsigned pos);
      for (int unsigned i = pos; i + 1 < blk_total; i++) begin
        blk_start[i] = blk_start[i + 1];
        blk_len[i] = blk_len[i + 1];
      end
      blk_total--;
    endfunction

    function logic [saffba_pkg::STAT_W-1:0] give_back(int unsigned ofs, int unsigned cnt);
      int unsigned pos;
      bit join_lo, join_hi;
      pos = 0;
      while (pos < blk_total && blk_start[pos] < ofs) pos++;
      join_lo = pos > 0 && longint'(blk_start[pos - 1]) + blk_len[pos - 1] == ofs;
      join_hi = pos < blk_total && longint'(ofs) + cnt == blk_start[pos];
      if (join_lo && join_hi) begin
        blk_len[pos - 1] += cnt + blk_len[pos];
        drop_block(pos);
      end else if (join_lo) begin
        blk_len[pos - 1] += cnt;
      end else if (join_hi) begin
        blk_start[pos] = ofs;
        blk_len[pos] += cnt;
      end else begin
        if (blk_total >= NFREE) return saffba_pkg::STAT_LIST_FULL;
        for (int unsigned i = blk_total; i > pos; i--) begin
          blk_start[i] = blk_start[i - 1];
          blk_len[i] = blk_len[i - 1];
        end
        blk_start[pos] = ofs;
        blk_len[pos] = cnt;
        blk_total++;
      end
      return saffba_pkg::STAT_OK;
    endfunction

    function grant_t note_transfer(logic rt, logic [saffba_pkg::CNT_W-1:0] c,
                                   logic [saffba_pkg::SID_W-1:0] s,
                                   logic [saffba_pkg::OFS_W-1:0] o);
      grant_t r;
      int unsigned pos, first, cnt, room, slot;
      bit fit;
      r.status = saffba_pkg::STAT_OK;
      r.slot = NO_GRANT;
      r.offset = '0;
      cnt = c;
      if (rt == REQ_ALLOC) begin
        if (slot_depth == 0) begin
          r.status = saffba_pkg::STAT_NO_SLOT;
        end else begin
          slot_depth--;
          slot = slot_stack[slot_depth];
          first = 0;
          fit = 1'b1;
          if (cnt > 0) begin
            pos = 0;
            while (pos < blk_total && blk_len[pos] < cnt) pos++;
            if (pos < blk_total) begin
              first = blk_start[pos];
              if (blk_len[pos] == cnt) drop_block(pos);
              else begin
                blk_start[pos] += cnt;
                blk_len[pos] -= cnt;
              end
            end else begin
              fit = 1'b0;
            end
          end
          if (!fit) begin
            slot_depth++;
            r.status = saffba_pkg::STAT_POOL_FULL;
          end else begin
            r.slot = saffba_pkg::SID_W'(slot);
            r.offset = saffba_pkg::OFS_W'(first);
          end
        end
      end else if (s >= NSLOT) begin
        r.status = saffba_pkg::STAT_INVALID;
      end else begin
        if (slot_depth < NSLOT) begin
          slot_stack[slot_depth] = s;
          slot_depth++;
        end
        if (o < NPOOL) begin
          room = NPOOL - o;
          if (cnt > room) cnt = room;
          if (cnt > 0) r.status = give_back(o, cnt);
        end
      end
      pending.insert(pending.size(), r);
      return r;
    endfunction

    function void check_result(grant_t got);
      grant_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d offset %0d",
                   got.status, got.slot, got.offset);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d slot %0d offset %0d, got %0d %0d %0d",
                   exp.status, exp.slot, exp.offset, got.status, got.slot, got.offset);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = 1'b0;
  logic [saffba_pkg::CNT_W-1:0] in_item_count = '0;
  logic [saffba_pkg::SID_W-1:0] in_slot_id = '0;
  logic [saffba_pkg::OFS_W-1:0] in_release_offset = '0;
  logic out_valid;
  logic [saffba_pkg::STAT_W-1:0] out_status;
  logic [saffba_pkg::SID_W-1:0] out_granted_slot;
  logic [saffba_pkg::OFS_W-1:0] out_granted_offset;

  alloc_scoreboard sb = new();
  lease_t leases[$];
  longint cycles = 0;

  always #6 clk = ~clk;

  slot_and_first_fit_block_allocator_core i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_item_count(in_item_count),
    .in_slot_id(in_slot_id),
    .in_release_offset(in_release_offset),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_granted_slot(out_granted_slot),
    .out_granted_offset(out_granted_offset)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result({out_status, out_granted_slot, out_granted_offset});
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(input logic rt, input logic [saffba_pkg::CNT_W-1:0] c,
                      input logic [saffba_pkg::SID_W-1:0] s,
                      input logic [saffba_pkg::OFS_W-1:0] o);
    grant_t g;
    lease_t l;
    start <= 1'b1;
    in_req_type <= rt;
    in_item_count <= c;
    in_slot_id <= s;
    in_release_offset <= o;
    do @(posedge clk); while (busy);
    g = sb.note_transfer(rt, c, s, o);
    if (rt == REQ_ALLOC && g.status == saffba_pkg::STAT_OK) begin
      l.slot = g.slot;
      l.offset = g.offset;
      l.count = c;
      leases.insert(leases.size(), l);
    end
  endtask

  task automatic release_lease(input int idx);
    lease_t l;
    l = leases[idx];
    leases.delete(idx);
    send(REQ_RELEASE, l.count, l.slot, l.offset);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    logic [saffba_pkg::CNT_W-1:0] c;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // slot stack full on release, zero count
    send(REQ_RELEASE, 0, 5, 0);
    send(REQ_ALLOC, 0, 0, 0);
    send(REQ_ALLOC, {saffba_pkg::CNT_W{1'b1}}, 0, 0);
    send(REQ_ALLOC, saffba_pkg::CNT_W'(NPOOL + 1), 0, 0);
    send(REQ_ALLOC, saffba_pkg::CNT_W'(NPOOL), 0, 0);
    send(REQ_ALLOC, 1, 0, 0);
    release_lease(leases.size() - 1);
    send(REQ_RELEASE, 7, NO_GRANT, 0);
    send(REQ_RELEASE, 7, {saffba_pkg::SID_W{1'b1}}, {saffba_pkg::OFS_W{1'b1}});
    send(REQ_ALLOC, 100, 0, 0);
    send(REQ_ALLOC, 50, 0, 0);
    send(REQ_ALLOC, 1, 0, 0);
    release_lease(0);
    release_lease(0);
    send(REQ_ALLOC, 16, 0, 0);
    send(REQ_RELEASE, 0, 3, 26'd12345);
    send(REQ_RELEASE, 4, 9, 0);
    send(REQ_RELEASE, {saffba_pkg::CNT_W{1'b1}}, 10, {saffba_pkg::OFS_W{1'b1}});
    send(REQ_RELEASE, 2, 11, {{(saffba_pkg::OFS_W - 1){1'b1}}, 1'b0});
    while (leases.size() > 0) release_lease(0);

    // exhaust the slot stack, then hand some back
    while (sb.slot_depth > 0) send(REQ_ALLOC, 0, 0, 0);
    send(REQ_ALLOC, 0, 0, 0);
    send(REQ_ALLOC, 8, 0, 0);
    repeat (24) release_lease($urandom_range(leases.size() - 1));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send(REQ_RELEASE, saffba_pkg::CNT_W'($urandom), saffba_pkg::SID_W'($urandom),
             saffba_pkg::OFS_W'($urandom));
      end else if (r < 7) begin
        send(REQ_RELEASE, saffba_pkg::CNT_W'($urandom_range(64)),
             saffba_pkg::SID_W'($urandom_range(2047, NSLOT)), saffba_pkg::OFS_W'($urandom));
      end else if (leases.size() > 0 && (r < 40 || (leases.size() >= 40 && r < 75))) begin
        release_lease($urandom_range(leases.size() - 1));
      end else begin
        r = $urandom_range(99);
        if (r < 5) c = 0;
        else if (r < 10) c = saffba_pkg::CNT_W'($urandom);
        else if (r < 14) c = saffba_pkg::CNT_W'($urandom_range(NPOOL / 2, NPOOL / 64));
        else c = saffba_pkg::CNT_W'($urandom_range(4096, 1));
        send(REQ_ALLOC, c, 0, 0);
      end
      if (n == 400) drain();
      else if ((n < 200 || n > 400) && $urandom_range(99) < 20) pause($urandom_range(8, 1));
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
